// File: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Register indexes, reset values and fixed constants of the barometric
// pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [REG_IDX_W-1:0] REG_AC1   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AC2   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AC3   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AC4   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AC5   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AC6   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_B1_B2 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MC_MD = 3'd7;

  localparam logic [15:0] RST_AC1   = 16'd408;
  localparam logic [15:0] RST_AC2   = 16'hFFB8;
  localparam logic [15:0] RST_AC3   = 16'hC7D1;
  localparam logic [15:0] RST_AC4   = 16'd32741;
  localparam logic [15:0] RST_AC5   = 16'd32757;
  localparam logic [15:0] RST_AC6   = 16'd23153;
  localparam logic [31:0] RST_B1_B2 = 32'd405667844;
  localparam logic [31:0] RST_MC_MD = 32'd3724086068;

  // divider lengths: temperature quotient and pressure quotient
  localparam int DIV1_STEPS = 27;
  localparam int DIV2_STEPS = 32;

  localparam logic signed [29:0] B6_OFFSET  = 30'sd4000;
  localparam logic [31:0]        B4_OFFSET  = 32'd32768;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic [11:0]        P_SQ_COEF  = 12'd3038;
  localparam logic [12:0]        P_LIN_COEF = 13'd7357;
  localparam logic signed [49:0] P_OFFSET   = 50'sd3791;

  localparam logic signed [15:0] T_MAX = 16'sh7FFF;
  localparam logic signed [15:0] T_MIN = 16'sh8000;
  localparam logic [17:0]        P_MAX = 18'h3FFFF;

endpackage

// File: src/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor,
// oversampling zero, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// One sample pair is taken every clock cycle while in_ready is high; the
// pipeline depth is set by the two pipelined restoring dividers (27 and 32
// steps, one quotient bit per stage), which take a new item each cycle while
// not stalled. A stall on the result side freezes the pipeline after one
// more transaction has gone into the output skid register. A zero divisor
// gives divide_fault with zero results; out-of-range results saturate.
module barometric_pressure_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        raw_temperature,
  input  logic [15:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] temperature_tenths,
  output logic [17:0]        pressure_pa,
  output logic               divide_fault
);

  localparam int D1N = bpc_pkg::DIV1_STEPS;
  localparam int D2N = bpc_pkg::DIV2_STEPS;

  // configuration
  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
  logic [31:0] b1b2, mcmd;
  logic signed [15:0] s_ac1, s_ac2, s_ac3, s_b1, s_b2, s_mc, s_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1  <= bpc_pkg::RST_AC1;
      ac2  <= bpc_pkg::RST_AC2;
      ac3  <= bpc_pkg::RST_AC3;
      ac4  <= bpc_pkg::RST_AC4;
      ac5  <= bpc_pkg::RST_AC5;
      ac6  <= bpc_pkg::RST_AC6;
      b1b2 <= bpc_pkg::RST_B1_B2;
      mcmd <= bpc_pkg::RST_MC_MD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bpc_pkg::REG_AC1:   ac1  <= cfg_data[15:0];
        bpc_pkg::REG_AC2:   ac2  <= cfg_data[15:0];
        bpc_pkg::REG_AC3:   ac3  <= cfg_data[15:0];
        bpc_pkg::REG_AC4:   ac4  <= cfg_data[15:0];
        bpc_pkg::REG_AC5:   ac5  <= cfg_data[15:0];
        bpc_pkg::REG_AC6:   ac6  <= cfg_data[15:0];
        bpc_pkg::REG_B1_B2: b1b2 <= cfg_data;
        bpc_pkg::REG_MC_MD: mcmd <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_ac1 = ac1;
  assign s_ac2 = ac2;
  assign s_ac3 = ac3;
  assign s_b1  = b1b2[31:16];
  assign s_b2  = b1b2[15:0];
  assign s_mc  = mcmd[31:16];
  assign s_md  = mcmd[15:0];

  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign in_ready = en;

  // stage 1: (ut - ac6) * ac5
  logic signed [16:0] c1_diff;
  logic signed [33:0] c1_prod;
  logic               s1_v;
  logic signed [33:0] s1_prod;
  logic [15:0]        s1_up;

  assign c1_diff = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
  assign c1_prod = 34'(c1_diff) * 34'($signed({1'b0, ac5}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= c1_prod;
      s1_up   <= raw_pressure;
    end
  end

  // stage 2: x1 and the temperature divisor
  logic signed [17:0] c2_x1;
  logic               s2_v;
  logic signed [17:0] s2_x1;
  logic signed [18:0] s2_dsum;
  logic [15:0]        s2_up;

  assign c2_x1 = s1_prod[32:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1   <= c2_x1;
      s2_dsum <= 19'(c2_x1) + 19'(s_md);
      s2_up   <= s1_up;
    end
  end

  // stage 3: magnitudes for the signed division, then the divider chain
  logic signed [18:0] c3_negd;
  logic signed [16:0] c3_negmc;
  logic [16:0]        c3_absmc;

  assign c3_negd  = -s2_dsum;
  assign c3_negmc = -17'(s_mc);
  assign c3_absmc = s_mc[15] ? c3_negmc : 17'(s_mc);

  logic               d1_v    [0:D1N];
  logic [17:0]        d1_r    [0:D1N];
  logic [D1N-1:0]     d1_nq   [0:D1N];
  logic [17:0]        d1_dm   [0:D1N];
  logic signed [17:0] d1_x1   [0:D1N];
  logic [15:0]        d1_up   [0:D1N];
  logic               d1_neg  [0:D1N];
  logic               d1_fz   [0:D1N];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
    end else if (en) begin
      d1_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0]   <= '0;
      d1_nq[0]  <= D1N'({c3_absmc, 11'b0});
      d1_dm[0]  <= s2_dsum[18] ? c3_negd[17:0] : s2_dsum[17:0];
      d1_x1[0]  <= s2_x1;
      d1_up[0]  <= s2_up;
      d1_neg[0] <= s_mc[15] ^ s2_dsum[18];
      d1_fz[0]  <= (s2_dsum == '0);
    end
  end

  for (genvar k = 0; k < D1N; k++) begin : g_div1
    logic [18:0] rs;
    logic        ge;
    assign rs = {d1_r[k], d1_nq[k][D1N-1]};
    assign ge = (rs >= {1'b0, d1_dm[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[k+1] <= 1'b0;
      end else if (en) begin
        d1_v[k+1] <= d1_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_r[k+1]   <= ge ? 18'(rs - {1'b0, d1_dm[k]}) : rs[17:0];
        d1_nq[k+1]  <= {d1_nq[k][D1N-2:0], ge};
        d1_dm[k+1]  <= d1_dm[k];
        d1_x1[k+1]  <= d1_x1[k];
        d1_up[k+1]  <= d1_up[k];
        d1_neg[k+1] <= d1_neg[k];
        d1_fz[k+1]  <= d1_fz[k];
      end
    end
  end

  // stage A: b5
  logic signed [27:0] ca_q;
  logic signed [27:0] ca_x2;
  logic               sa_v;
  logic signed [28:0] sa_b5;
  logic [15:0]        sa_up;
  logic               sa_fz;

  assign ca_q  = $signed({1'b0, d1_nq[D1N]});
  assign ca_x2 = d1_neg[D1N] ? -ca_q : ca_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= 1'b0;
    end else if (en) begin
      sa_v <= d1_v[D1N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_b5 <= 29'(d1_x1[D1N]) + 29'(ca_x2);
      sa_up <= d1_up[D1N];
      sa_fz <= d1_fz[D1N];
    end
  end

  // stage B: temperature and b6
  logic signed [28:0] cb_tsum;
  logic signed [24:0] cb_tf;
  logic signed [15:0] cb_t;
  logic               sb_v;
  logic signed [15:0] sb_t;
  logic signed [29:0] sb_b6;
  logic [15:0]        sb_up;
  logic               sb_fz;

  assign cb_tsum = sa_b5 + 29'sd8;
  assign cb_tf   = cb_tsum[28:4];

  always_comb begin
    if (cb_tf > 25'(bpc_pkg::T_MAX)) begin
      cb_t = bpc_pkg::T_MAX;
    end else if (cb_tf < 25'(bpc_pkg::T_MIN)) begin
      cb_t = bpc_pkg::T_MIN;
    end else begin
      cb_t = cb_tf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else if (en) begin
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_t  <= cb_t;
      sb_b6 <= 30'(sa_b5) - bpc_pkg::B6_OFFSET;
      sb_up <= sa_up;
      sb_fz <= sa_fz;
    end
  end

  // stage C: b6 squared and linear terms
  logic               sc_v;
  logic signed [59:0] sc_sqf;
  logic signed [45:0] sc_mac2;
  logic signed [45:0] sc_mac3;
  logic signed [15:0] sc_t;
  logic [15:0]        sc_up;
  logic               sc_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else if (en) begin
      sc_v <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_sqf  <= 60'(sb_b6) * 60'(sb_b6);
      sc_mac2 <= 46'(s_ac2) * 46'(sb_b6);
      sc_mac3 <= 46'(s_ac3) * 46'(sb_b6);
      sc_t    <= sb_t;
      sc_up   <= sb_up;
      sc_fz   <= sb_fz;
    end
  end

  // stage D: sq
  logic               sd_v;
  logic [47:0]        sd_sq;
  logic signed [45:0] sd_mac2;
  logic signed [45:0] sd_mac3;
  logic signed [15:0] sd_t;
  logic [15:0]        sd_up;
  logic               sd_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= 1'b0;
    end else if (en) begin
      sd_v <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_sq   <= sc_sqf[59:12];
      sd_mac2 <= sc_mac2;
      sd_mac3 <= sc_mac3;
      sd_t    <= sc_t;
      sd_up   <= sc_up;
      sd_fz   <= sc_fz;
    end
  end

  // stage E: b1 and b2 products
  logic signed [48:0] ce_sq;
  logic               se_v;
  logic signed [63:0] se_pb2;
  logic signed [63:0] se_pb1;
  logic signed [34:0] se_x2a;
  logic signed [32:0] se_x1b;
  logic signed [15:0] se_t;
  logic [15:0]        se_up;
  logic               se_fz;

  assign ce_sq = $signed({1'b0, sd_sq});

  always_ff @(posedge clk) begin
    if (rst) begin
      se_v <= 1'b0;
    end else if (en) begin
      se_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_pb2 <= 64'(s_b2) * 64'(ce_sq);
      se_pb1 <= 64'(s_b1) * 64'(ce_sq);
      se_x2a <= sd_mac2[45:11];
      se_x1b <= sd_mac3[45:13];
      se_t   <= sd_t;
      se_up  <= sd_up;
      se_fz  <= sd_fz;
    end
  end

  // stage F: b3 and x3
  logic signed [63:0] cf_s;
  logic signed [63:0] cf_sr;
  logic signed [63:0] cf_b3;
  logic signed [63:0] cf_x3s;
  logic signed [63:0] cf_x3;
  logic               sf_v;
  logic [31:0]        sf_b3;
  logic [31:0]        sf_x3;
  logic signed [15:0] sf_t;
  logic [15:0]        sf_up;
  logic               sf_fz;

  assign cf_s   = (64'(s_ac1) <<< 2) + (se_pb2 >>> 11) + 64'(se_x2a) + 64'sd2;
  assign cf_sr  = cf_s[63] ? cf_s + 64'sd3 : cf_s;
  assign cf_b3  = cf_sr >>> 2;
  assign cf_x3s = (se_pb1 >>> 16) + 64'(se_x1b) + 64'sd2;
  assign cf_x3  = cf_x3s >>> 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_v <= 1'b0;
    end else if (en) begin
      sf_v <= se_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_b3 <= cf_b3[31:0];
      sf_x3 <= cf_x3[31:0];
      sf_t  <= se_t;
      sf_up <= se_up;
      sf_fz <= se_fz;
    end
  end

  // stage G: b4 and b7, modulo 2^32
  logic [31:0]        cg_b4p;
  logic               sg_v;
  logic [16:0]        sg_b4;
  logic [31:0]        sg_b7;
  logic signed [15:0] sg_t;
  logic               sg_fz;

  assign cg_b4p = 32'({16'b0, ac4} * (sf_x3 + bpc_pkg::B4_OFFSET));

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_v <= 1'b0;
    end else if (en) begin
      sg_v <= sf_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_b4 <= cg_b4p[31:15];
      sg_b7 <= 32'(({16'b0, sf_up} - sf_b3) * bpc_pkg::B7_SCALE);
      sg_t  <= sf_t;
      sg_fz <= sf_fz;
    end
  end

  // stage H and the pressure divider chain
  logic               d2_v   [0:D2N];
  logic [16:0]        d2_r   [0:D2N];
  logic [D2N-1:0]     d2_nq  [0:D2N];
  logic [16:0]        d2_dm  [0:D2N];
  logic               d2_big [0:D2N];
  logic               d2_flt [0:D2N];
  logic signed [15:0] d2_t   [0:D2N];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v[0] <= 1'b0;
    end else if (en) begin
      d2_v[0] <= sg_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0]   <= '0;
      d2_nq[0]  <= sg_b7[31] ? sg_b7 : {sg_b7[30:0], 1'b0};
      d2_dm[0]  <= sg_b4;
      d2_big[0] <= sg_b7[31];
      d2_flt[0] <= sg_fz || (sg_b4 == '0);
      d2_t[0]   <= sg_t;
    end
  end

  for (genvar k = 0; k < D2N; k++) begin : g_div2
    logic [17:0] rs;
    logic        ge;
    assign rs = {d2_r[k], d2_nq[k][D2N-1]};
    assign ge = (rs >= {1'b0, d2_dm[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[k+1] <= 1'b0;
      end else if (en) begin
        d2_v[k+1] <= d2_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_r[k+1]   <= ge ? 17'(rs - {1'b0, d2_dm[k]}) : rs[16:0];
        d2_nq[k+1]  <= {d2_nq[k][D2N-2:0], ge};
        d2_dm[k+1]  <= d2_dm[k];
        d2_big[k+1] <= d2_big[k];
        d2_flt[k+1] <= d2_flt[k];
        d2_t[k+1]   <= d2_t[k];
      end
    end
  end

  // stage I: p
  logic               si_v;
  logic [31:0]        si_p;
  logic signed [15:0] si_t;
  logic               si_flt;

  always_ff @(posedge clk) begin
    if (rst) begin
      si_v <= 1'b0;
    end else if (en) begin
      si_v <= d2_v[D2N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      si_p   <= d2_big[D2N] ? {d2_nq[D2N][30:0], 1'b0} : d2_nq[D2N];
      si_t   <= d2_t[D2N];
      si_flt <= d2_flt[D2N];
    end
  end

  // stage J: (p >> 8)^2 and p * 7357
  logic               sj_v;
  logic [47:0]        sj_sqp;
  logic [44:0]        sj_pm;
  logic [31:0]        sj_p;
  logic signed [15:0] sj_t;
  logic               sj_flt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sj_v <= 1'b0;
    end else if (en) begin
      sj_v <= si_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sj_sqp <= 48'(si_p[31:8]) * 48'(si_p[31:8]);
      sj_pm  <= 45'(si_p) * 45'(bpc_pkg::P_LIN_COEF);
      sj_p   <= si_p;
      sj_t   <= si_t;
      sj_flt <= si_flt;
    end
  end

  // stage K: square term times 3038
  logic               sk_v;
  logic [59:0]        sk_x1m;
  logic [44:0]        sk_pm;
  logic [31:0]        sk_p;
  logic signed [15:0] sk_t;
  logic               sk_flt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_v <= 1'b0;
    end else if (en) begin
      sk_v <= sj_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk_x1m <= 60'(sj_sqp) * 60'(bpc_pkg::P_SQ_COEF);
      sk_pm  <= sj_pm;
      sk_p   <= sj_p;
      sk_t   <= sj_t;
      sk_flt <= sj_flt;
    end
  end

  // stage L: final pressure, saturation and fault zeroing
  logic signed [45:0] cl_negpm;
  logic signed [29:0] cl_x2;
  logic signed [49:0] cl_corr;
  logic signed [49:0] cl_pres;
  logic [17:0]        cl_p;
  logic signed [15:0] cl_t;
  logic               emit;

  assign cl_negpm = -$signed({1'b0, sk_pm});
  assign cl_x2    = cl_negpm[45:16];
  assign cl_corr  = $signed({6'b0, sk_x1m[59:16]}) + 50'(cl_x2) + bpc_pkg::P_OFFSET;
  assign cl_pres  = $signed({18'b0, sk_p}) + (cl_corr >>> 4);

  always_comb begin
    if (sk_flt || cl_pres < 50'sd0) begin
      cl_p = '0;
    end else if (cl_pres > $signed({32'b0, bpc_pkg::P_MAX})) begin
      cl_p = bpc_pkg::P_MAX;
    end else begin
      cl_p = cl_pres[17:0];
    end
  end

  assign cl_t = sk_flt ? 16'sd0 : sk_t;
  assign emit = en && sk_v;

  // output register with skid
  logic signed [15:0] skid_t;
  logic [17:0]        skid_p;
  logic               skid_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_v) begin
        temperature_tenths <= skid_t;
        pressure_pa        <= skid_p;
        divide_fault       <= skid_f;
      end else begin
        temperature_tenths <= cl_t;
        pressure_pa        <= cl_p;
        divide_fault       <= sk_flt;
      end
    end else if (emit) begin
      skid_t <= cl_t;
      skid_p <= cl_p;
      skid_f <= sk_flt;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid register full while output empty");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |-> (temperature_tenths == '0 && pressure_pa == '0))
    else $error("fault transaction with non-zero results");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && !out_ready))
    else $error("skid register filled without a stalled output");

endmodule

// File: sim/barometric_pressure_compensation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_test
// Self-checking bench for the barometric pressure compensation pipeline.
// A short table of directed pairs is followed by random pairs under a series
// of calibration sets, with idle and stall patterns on both channels. Each
// result is compared with a typed table entry or a local integer model.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_test;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               fault;
  } comp_result_t;

  typedef enum int {
    CAL_RESET, CAL_RANDOM, CAL_ZERO, CAL_ONES, CAL_EXTREME, CAL_NEAR, CAL_NO_B4
  } cal_kind_e;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    cal_kind_e    cal;
    logic [15:0]  ut;
    logic [15:0]  up;
    bit           typed;
    comp_result_t res;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        raw_temperature = '0;
  logic [15:0]        raw_pressure = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] temperature_tenths;
  logic [17:0]        pressure_pa;
  logic               divide_fault;

  logic [31:0]  cal_copy [8];
  comp_result_t pending_results [$];
  idle_mode_e   idle_mode = IDLE_NONE;
  bit           cur_typed = 1'b0;
  comp_result_t cur_res;
  bit           hold_req = 1'b0;
  int           hold_cnt = 0;
  int           mismatches = 0;
  int           results_seen = 0;
  int           faults_seen = 0;
  int           phases_run = 0;

  barometric_pressure_compensation dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic comp_result_t compensate(logic [15:0] ut_w, logic [15:0] up_w);
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, b3, b5, b6, t, p, pres, sq;
    int unsigned ac4, b4, b7, q;
    comp_result_t r;
    ac1 = $signed(cal_copy[bpc_pkg::REG_AC1][15:0]);
    ac2 = $signed(cal_copy[bpc_pkg::REG_AC2][15:0]);
    ac3 = $signed(cal_copy[bpc_pkg::REG_AC3][15:0]);
    ac4 = cal_copy[bpc_pkg::REG_AC4][15:0];
    ac5 = cal_copy[bpc_pkg::REG_AC5][15:0];
    ac6 = cal_copy[bpc_pkg::REG_AC6][15:0];
    b1  = $signed(cal_copy[bpc_pkg::REG_B1_B2][31:16]);
    b2  = $signed(cal_copy[bpc_pkg::REG_B1_B2][15:0]);
    mc  = $signed(cal_copy[bpc_pkg::REG_MC_MD][31:16]);
    md  = $signed(cal_copy[bpc_pkg::REG_MC_MD][15:0]);
    ut  = ut_w;
    up  = up_w;
    r   = '{temp: '0, pres: '0, fault: 1'b1};
    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3 + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * 32'(x3 + 32768)) >> 15;
    if (b4 == 0) return r;
    b7 = 32'(up - b3) * 32'd50000;
    if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
    else q = (b7 / b4) * 32'd2;
    p = {32'd0, q};
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    pres = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (pres < 0) pres = 0;
    if (pres > 262143) pres = 262143;
    r = '{temp: t[15:0], pres: pres[17:0], fault: 1'b0};
    return r;
  endfunction

  // input side: record expectation for every accepted transaction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_results.push_back(cur_typed ? cur_res : compensate(raw_temperature, raw_pressure));
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (divide_fault) faults_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result t=%0d p=%0d f=%0b",
                                       temperature_tenths, pressure_pa, divide_fault);
      end else begin
        want = pending_results.pop_front();
        if (want.temp !== temperature_tenths || want.pres !== pressure_pa ||
            want.fault !== divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
                     want.temp, want.pres, want.fault,
                     temperature_tenths, pressure_pa, divide_fault);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready = ($urandom_range(99) >= 53);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready = ($urandom_range(99) >= 31);
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    cal_copy[idx] = (idx == bpc_pkg::REG_B1_B2 || idx == bpc_pkg::REG_MC_MD) ?
                    val : {16'd0, val[15:0]};
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_cal(cal_kind_e kind);
    logic [31:0] v [8];
    v = '{32'(bpc_pkg::RST_AC1), 32'(bpc_pkg::RST_AC2), 32'(bpc_pkg::RST_AC3),
          32'(bpc_pkg::RST_AC4), 32'(bpc_pkg::RST_AC5), 32'(bpc_pkg::RST_AC6),
          bpc_pkg::RST_B1_B2, bpc_pkg::RST_MC_MD};
    for (int i = 0; i < 8; i++) begin
      case (kind)
        CAL_RANDOM:  v[i] = $urandom;
        CAL_ZERO:    v[i] = '0;
        CAL_ONES:    v[i] = '1;
        CAL_EXTREME: v[i] = ($urandom_range(1)) ? 32'h7FFF_8000 : 32'h8000_7FFF;
        CAL_NEAR:    v[i] = v[i] + $urandom_range(64) - 32;
        CAL_NO_B4:   if (i == bpc_pkg::REG_AC4) v[i] = '0;
        default: ;
      endcase
    end
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
    phases_run++;
  endtask

  task automatic send(logic [15:0] ut, logic [15:0] up);
    int gap;
    gap = 0;
    if (idle_mode == IDLE_SEND)
      while ($urandom_range(99) < 53) gap++;
    else if (idle_mode == IDLE_BOTH)
      while ($urandom_range(99) < 31) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    raw_temperature = ut;
    raw_pressure = up;
    do @(posedge clk); while (!in_ready);
  endtask

  directed_row_t rows [] = '{
    '{CAL_RESET, 16'd27898, 16'd23843, 1, '{16'sd150, 18'd69964, 1'b0}},
    '{CAL_RESET, 16'd0,     16'd0,     0, '{default: '0}},
    '{CAL_RESET, 16'hFFFF,  16'hFFFF,  0, '{default: '0}},
    '{CAL_RESET, 16'd0,     16'hFFFF,  0, '{default: '0}},
    '{CAL_RESET, 16'hFFFF,  16'd0,     0, '{default: '0}},
    '{CAL_RESET, 16'h8000,  16'h8000,  0, '{default: '0}},
    '{CAL_RESET, 16'h5A71,  16'h7FFF,  0, '{default: '0}},
    '{CAL_ZERO,  16'd27898, 16'd23843, 1, '{16'sd0, 18'd0, 1'b1}},
    '{CAL_ZERO,  16'hFFFF,  16'hFFFF,  1, '{16'sd0, 18'd0, 1'b1}},
    '{CAL_NO_B4, 16'd27898, 16'd23843, 1, '{16'sd0, 18'd0, 1'b1}},
    '{CAL_NO_B4, 16'd0,     16'hFFFF,  1, '{16'sd0, 18'd0, 1'b1}},
    '{CAL_ONES,  16'd0,     16'd0,     0, '{default: '0}},
    '{CAL_ONES,  16'hFFFF,  16'hFFFF,  0, '{default: '0}},
    '{CAL_EXTREME, 16'd0,   16'hFFFF,  0, '{default: '0}},
    '{CAL_EXTREME, 16'hFFFF, 16'd0,    0, '{default: '0}}
  };

  initial begin
    cal_kind_e kinds [];
    cal_kind_e last;
    kinds = '{CAL_RESET, CAL_RANDOM, CAL_NEAR, CAL_EXTREME, CAL_RANDOM,
              CAL_RESET, CAL_ONES, CAL_RANDOM, CAL_NEAR, CAL_ZERO,
              CAL_RANDOM, CAL_RESET, CAL_NO_B4, CAL_RANDOM, CAL_NEAR,
              CAL_RESET};
    cal_copy = '{32'(bpc_pkg::RST_AC1), 32'(bpc_pkg::RST_AC2), 32'(bpc_pkg::RST_AC3),
                 32'(bpc_pkg::RST_AC4), 32'(bpc_pkg::RST_AC5), 32'(bpc_pkg::RST_AC6),
                 bpc_pkg::RST_B1_B2, bpc_pkg::RST_MC_MD};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    last = CAL_RESET;
    foreach (rows[i]) begin
      if (rows[i].cal != last) begin
        load_cal(rows[i].cal);
        last = rows[i].cal;
      end
      cur_typed = rows[i].typed;
      cur_res = rows[i].res;
      send(rows[i].ut, rows[i].up);
    end
    @(negedge clk);
    cur_typed = 1'b0;
    foreach (kinds[k]) begin
      load_cal(kinds[k]);
      idle_mode = idle_mode_e'(k % 4);
      for (int n = 0; n < 125; n++) begin
        if (k == 5 && n == 10) hold_req = 1'b1;
        if ($urandom_range(99) < 60)
          send(16'($urandom_range(35000, 20000)), 16'($urandom_range(45000, 15000)));
        else
          send(16'($urandom), 16'($urandom));
      end
    end
    drain();
    $display("%0d results checked over %0d calibration sets, %0d with divide fault",
             results_seen, phases_run, faults_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
